// ----- sv/cv3_pkg.sv -----
package cv3_pkg;

    localparam int PIXEL_W            = 8;
    localparam int POS_W              = 10;
    localparam int SUM_W              = 20;
    localparam int PROD_W             = 17;
    localparam int ROWSUM_W           = 19;
    localparam int BIAS_W             = 16;
    localparam int DIM_W              = 11;
    localparam int KROW_W             = 24;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 24;
    localparam int MAX_HEIGHT         = 1024;
    localparam int JOB_QUEUE_DEPTH    = 4;
    localparam int RESULT_QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_BIAS          = 3'd3,
        REG_IMAGE_WIDTH   = 3'd4,
        REG_IMAGE_HEIGHT  = 3'd5
    } cv3_reg_idx_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } cv3_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
        logic                    last;
    } cv3_result_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cv3_geom_t;

    typedef struct packed {
        logic [2:0][KROW_W-1:0]   rows;
        logic signed [BIAS_W-1:0] bias;
    } cv3_kernel_t;

    typedef logic [2:0][2:0][PIXEL_W-1:0] cv3_window_t;

    typedef struct packed {
        cv3_window_t      win;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last;
    } cv3_job_t;

endpackage

// ----- sv/cv3_fifo.sv -----
module cv3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (!push && do_pop)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // The producers reserve space ahead of time, so the queue must never overflow.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |-> count_reg != CW'(DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (count_reg == '0) |=> count_reg == CW'($past(push)))
        else $error("read of an empty queue changed its count");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

// ----- sv/cv3_front.sv -----
module cv3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  cv3_pkg::cv3_item_t     item,
    input  cv3_pkg::cv3_geom_t     geom,
    output logic                   job_push,
    output cv3_pkg::cv3_job_t      job,
    input  logic [$clog2(cv3_pkg::JOB_QUEUE_DEPTH+1)-1:0] job_count
);

    import cv3_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int QCW  = $clog2(JOB_QUEUE_DEPTH + 1);

    logic [PIXEL_W-1:0] top_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] mid_mem [MAX_WIDTH];

    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   row_next;

    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic               s1_produce_reg;
    logic [POS_W-1:0]   s1_row_reg;
    logic [POS_W-1:0]   s1_col_reg;
    logic               s1_last_reg;
    logic               s1_fwd_reg;
    logic [PIXEL_W-1:0] s1_fwd_top_reg;
    logic [PIXEL_W-1:0] s1_fwd_mid_reg;
    logic [PIXEL_W-1:0] top_rd_reg;
    logic [PIXEL_W-1:0] mid_rd_reg;
    logic [PIXEL_W-1:0] top_eff;
    logic [PIXEL_W-1:0] mid_eff;

    cv3_window_t        win_reg;
    cv3_window_t        win_next;

    logic               accept;
    logic [CMPW-1:0]    w_raw;
    logic [CMPW-1:0]    w_use;
    logic [DIM_W-1:0]   h_use;
    logic [CMPW-1:0]    col_start;
    logic [CMPW-1:0]    col_cur;
    logic [DIM_W-1:0]   row_start;
    logic [DIM_W-1:0]   row_cur;
    logic [CW-1:0]      addr;
    logic               row_end;
    logic               frame_end;
    logic [CMPW-1:0]    col_off;
    logic [DIM_W-1:0]   row_off;
    logic [QCW:0]       in_flight;

    assign in_flight = (QCW + 1)'(job_count) + (QCW + 1)'(s1_valid_reg);
    assign full      = (in_flight >= (QCW + 1)'(JOB_QUEUE_DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        w_raw = CMPW'(geom.image_width);
        if (w_raw < CMPW'(3))
        begin
            w_use = CMPW'(3);
        end
        else if (w_raw > CMPW'(MAX_WIDTH))
        begin
            w_use = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_use = w_raw;
        end

        if (geom.image_height < DIM_W'(3))
        begin
            h_use = DIM_W'(3);
        end
        else if (geom.image_height > DIM_W'(MAX_HEIGHT))
        begin
            h_use = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_use = geom.image_height;
        end

        col_start = item.frame_start ? '0 : CMPW'(col_reg);
        row_start = item.frame_start ? '0 : DIM_W'(row_reg);
        col_cur   = (col_start >= w_use) ? CMPW'(w_use - 1'b1) : col_start;
        row_cur   = (row_start >= h_use) ? DIM_W'(h_use - 1'b1) : row_start;
        addr      = col_cur[CW-1:0];
        row_end   = (col_cur == CMPW'(w_use - 1'b1));
        frame_end = (row_cur == DIM_W'(h_use - 1'b1));
        col_off   = CMPW'(col_cur - CMPW'(2));
        row_off   = DIM_W'(row_cur - DIM_W'(2));

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : POS_W'(row_cur + 1'b1);
            end
            else
            begin
                col_next = CW'(col_cur + 1'b1);
                row_next = row_cur[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            win_reg      <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= item.pixel;
            s1_addr_reg    <= addr;
            s1_produce_reg <= (row_cur >= DIM_W'(2)) && (col_cur >= CMPW'(2));
            s1_row_reg     <= row_off[POS_W-1:0];
            s1_col_reg     <= col_off[POS_W-1:0];
            s1_last_reg    <= row_end && frame_end;
            s1_fwd_reg     <= s1_valid_reg && (s1_addr_reg == addr);
            s1_fwd_top_reg <= mid_eff;
            s1_fwd_mid_reg <= s1_px_reg;
        end
    end

    // Row-2 line buffer: takes over the row-1 byte that the item moves up.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            top_mem[s1_addr_reg] <= mid_eff;
        end
        if (accept)
        begin
            top_rd_reg <= top_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mid_mem[s1_addr_reg] <= s1_px_reg;
        end
        if (accept)
        begin
            mid_rd_reg <= mid_mem[addr];
        end
    end

    // When the previous item writes the column being read, its values are forwarded.
    assign top_eff = s1_fwd_reg ? s1_fwd_top_reg : top_rd_reg;
    assign mid_eff = s1_fwd_reg ? s1_fwd_mid_reg : mid_rd_reg;

    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = top_eff;
            win_next[1][2] = mid_eff;
            win_next[2][2] = s1_px_reg;
        end
    end

    assign job_push    = s1_valid_reg && s1_produce_reg;
    assign job.win     = win_next;
    assign job.out_row = s1_row_reg;
    assign job.out_col = s1_col_reg;
    assign job.last    = s1_last_reg;

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the window stage");

    a_fwd_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) && s1_fwd_reg |-> $past(s1_valid_reg))
        else $error("forwarding without a preceding pixel");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(col_reg) < CMPW'(MAX_WIDTH))
        else $error("column counter beyond line buffer depth");

endmodule

// ----- sv/cv3_back.sv -----
module cv3_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cv3_pkg::cv3_job_t    job,
    input  logic                 job_empty,
    output logic                 job_pop,
    input  cv3_pkg::cv3_kernel_t kernel,
    output cv3_pkg::cv3_result_t result,
    output logic                 empty,
    input  logic                 pop
);

    import cv3_pkg::*;

    localparam int RCW = $clog2(RESULT_QUEUE_DEPTH + 1);

    logic                            a_valid_reg;
    logic signed [PROD_W-1:0]        prod_reg [3][3];
    logic [POS_W-1:0]                a_row_reg;
    logic [POS_W-1:0]                a_col_reg;
    logic                            a_last_reg;

    logic                            b_valid_reg;
    logic signed [ROWSUM_W-1:0]      rowsum_reg [3];
    logic [POS_W-1:0]                b_row_reg;
    logic [POS_W-1:0]                b_col_reg;
    logic                            b_last_reg;

    logic signed [SUM_W-1:0]         sum_next;
    cv3_result_t                     res_next;
    logic [RCW-1:0]                  res_count;
    logic [RCW:0]                    res_flight;

    assign res_flight = (RCW + 1)'(res_count) + (RCW + 1)'(a_valid_reg)
                      + (RCW + 1)'(b_valid_reg);
    assign job_pop    = !job_empty && (res_flight < (RCW + 1)'(RESULT_QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= job_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(signed'({1'b0, job.win[r][c]})
                                    * signed'(kernel.rows[r][8*c +: 8]));
                end
            end
            a_row_reg  <= job.out_row;
            a_col_reg  <= job.out_col;
            a_last_reg <= job.last;
        end
        if (a_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rowsum_reg[r] <= ROWSUM_W'(prod_reg[r][0]) + ROWSUM_W'(prod_reg[r][1])
                               + ROWSUM_W'(prod_reg[r][2]);
            end
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign sum_next = SUM_W'(rowsum_reg[0]) + SUM_W'(rowsum_reg[1])
                    + SUM_W'(rowsum_reg[2]) + SUM_W'(kernel.bias);

    assign res_next.sum     = sum_next;
    assign res_next.out_row = b_row_reg;
    assign res_next.out_col = b_col_reg;
    assign res_next.last    = b_last_reg;

    cv3_fifo #(
        .WIDTH ($bits(cv3_result_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid_reg),
        .wdata (res_next),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .count (res_count)
    );

endmodule

// ----- sv/conv2d_3x3_valid.sv -----
// Channel   Handshake          Payload                          Transfer when
// item      push / full        pixel, frame_start               push && !full
// result    empty / pop        sum, out_row, out_col, last      pop && !empty
// config    wr_en              wr_index, wr_data                wr_en
//
// One pixel is taken per clock while full is low; a result leaves the input stage in the
// cycle after its pixel and passes through the job queue and the product and row-sum registers to the result queue.
// The line buffers are read and written once per pixel, one port each.
// Reset clears counters, window and queues; line buffers are not cleared.
// full rises when the job queue entries, together with any pixel in flight, take up its depth.
// A stalled result side fills the result queue, then the job queue, then full.
module conv2d_3x3_valid #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  cv3_pkg::cv3_item_t                  item,
    output logic                                empty,
    input  logic                                pop,
    output cv3_pkg::cv3_result_t                result,
    input  logic                                wr_en,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [cv3_pkg::CFG_DATA_W-1:0]      wr_data
);

    import cv3_pkg::*;

    localparam int QCW = $clog2(JOB_QUEUE_DEPTH + 1);

    cv3_kernel_t     kernel_reg;
    cv3_geom_t       geom_reg;
    cv3_job_t        job_in;
    cv3_job_t        job_out;
    logic            job_push;
    logic            job_pop;
    logic            job_empty;
    logic [QCW-1:0]  job_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg.rows        <= '0;
            kernel_reg.bias        <= BIAS_W'(1);
            geom_reg.image_width   <= DIM_W'(5);
            geom_reg.image_height  <= DIM_W'(5);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_KERNEL_TOP:    kernel_reg.rows[0] <= wr_data;
                REG_KERNEL_MIDDLE: kernel_reg.rows[1] <= wr_data;
                REG_KERNEL_BOTTOM: kernel_reg.rows[2] <= wr_data;
                REG_BIAS:          kernel_reg.bias <= wr_data[BIAS_W-1:0];
                REG_IMAGE_WIDTH:   geom_reg.image_width <= wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  geom_reg.image_height <= wr_data[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    cv3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .geom      (geom_reg),
        .job_push  (job_push),
        .job       (job_in),
        .job_count (job_count)
    );

    cv3_fifo #(
        .WIDTH ($bits(cv3_job_t)),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty),
        .count (job_count)
    );

    cv3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .kernel    (kernel_reg),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
